// File: sv/jhs_pkg.sv
// ----------------------------------------------------------------------------
// jhs_pkg: shared definitions for the jacobi heat stencil sweep
// Sizes of the line buffers and fields, register indexes and result type.
// ----------------------------------------------------------------------------
package jhs_pkg;

  // line buffer depth and temperature width
  localparam int LINE_LEN  = 1024;
  localparam int TEMP_BITS = 16;
  localparam int ADDR_W    = $clog2(LINE_LEN);

  // register field widths
  localparam int COLS_W = 11;
  localparam int ROWS_W = 16;
  localparam int CFG_W  = 16;
  localparam int IDX_W  = 2;

  // register indexes on the configuration port
  typedef enum logic [IDX_W-1:0] {
    CFG_COLUMN_COUNT      = 2'd0,
    CFG_ROW_COUNT         = 2'd1,
    CFG_UPDATE_TOP_ROW    = 2'd2,
    CFG_UPDATE_BOTTOM_ROW = 2'd3
  } cfg_idx_e;

  // geometry limits
  localparam logic [COLS_W-1:0] COLS_MIN = COLS_W'(3);
  localparam logic [COLS_W-1:0] COLS_MAX = COLS_W'(LINE_LEN);
  localparam logic [ROWS_W-1:0] ROWS_MIN = ROWS_W'(3);

  // one result beat
  typedef struct packed {
    logic [TEMP_BITS-1:0] new_value;
    logic [ROWS_W-1:0]    out_row;
    logic [ADDR_W-1:0]    out_col;
    logic                 frame_done;
  } res_t;

endpackage

// File: sv/jhs_in_if.sv
// ----------------------------------------------------------------------------
// jhs_in_if: cell input channel
// Valid/ready channel carrying one old cell temperature per beat.
// ----------------------------------------------------------------------------
interface jhs_in_if
  import jhs_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [TEMP_BITS-1:0] cell_value;

  modport source (output valid, output cell_value, input ready);
  modport sink   (input valid, input cell_value, output ready);
endinterface

// File: sv/jhs_out_if.sv
// ----------------------------------------------------------------------------
// jhs_out_if: result output channel
// Valid/ready channel carrying one new cell temperature and its position.
// ----------------------------------------------------------------------------
interface jhs_out_if
  import jhs_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [TEMP_BITS-1:0] new_value;
  logic [ROWS_W-1:0]    out_row;
  logic [ADDR_W-1:0]    out_col;
  logic                 frame_done;

  modport source (output valid, output new_value, output out_row, output out_col,
                  output frame_done, input ready);
  modport sink   (input valid, input new_value, input out_row, input out_col,
                  input frame_done, output ready);
endinterface

// File: sv/jacobi_heat_stencil_sweep.sv
// ----------------------------------------------------------------------------
// jacobi_heat_stencil_sweep: one Jacobi sweep of a streamed grid strip
// Four-neighbour mean over two line buffers for interior cells, one result per cell beat after row 0.
// ----------------------------------------------------------------------------
// Cells stream in raster order; each input beat for cell (r,c) yields the new
// value of cell (r-1,c), so row 0 produces nothing and the last row is never
// emitted. Throughput is one beat per clock while results are accepted: the
// line buffers are read ahead into registers at the address of the next
// expected cell, so the three reads (center and right from the previous row,
// up from the row before) are ready when the beat arrives. Input also stalls
// after reset and after each register write, while the prefetched line buffer
// data is refetched for the new geometry. Results leave through an output
// register backed by a skid register, so one input beat is still taken while
// a result waits; input then stalls while the skid register is full. The line
// buffers hold no reset value and need no clearing pass.
module jacobi_heat_stencil_sweep
  import jhs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_W-1:0]  cfg_data_i,
  jhs_in_if.sink            cell_i,
  jhs_out_if.source         result_o
);

  // registers
  logic [COLS_W-1:0] cols_q;
  logic [ROWS_W-1:0] rows_q;
  logic              upd_top_q;
  logic              upd_bot_q;

  // stream position and left neighbour
  logic [ADDR_W-1:0]    col_pos_q, col_pos_d;
  logic [ROWS_W-1:0]    row_pos_q, row_pos_d;
  logic [TEMP_BITS-1:0] left_q;
  logic                 rd_ok_q;

  // line buffers and their registered read data
  logic [TEMP_BITS-1:0] row_above_mem [LINE_LEN];
  logic [TEMP_BITS-1:0] two_above_mem [LINE_LEN];
  logic [TEMP_BITS-1:0] center_q, right_q, up_q;
  logic [ADDR_W-1:0]    rd_addr, rd_addr_nxt;

  // output stage
  res_t main_q, skid_q, res;
  logic main_v_q, skid_v_q;

  // effective geometry and clamped position
  logic [COLS_W-1:0] cols_eff;
  logic [ROWS_W-1:0] rows_eff;
  logic [ADDR_W-1:0] c_eff;
  logic [ROWS_W-1:0] r_eff;
  logic [ROWS_W-1:0] er;
  logic              c_last, r_last, upd, res_v, in_fire;
  logic [TEMP_BITS+1:0] sum;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q    <= COLS_MAX;
      rows_q    <= ROWS_W'(1024);
      upd_top_q <= 1'b0;
      upd_bot_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_COLUMN_COUNT:      cols_q    <= cfg_data_i[COLS_W-1:0];
        CFG_ROW_COUNT:         rows_q    <= cfg_data_i[ROWS_W-1:0];
        CFG_UPDATE_TOP_ROW:    upd_top_q <= cfg_data_i[0];
        CFG_UPDATE_BOTTOM_ROW: upd_bot_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // geometry saturation and position clamp
  always_comb begin
    cols_eff = cols_q;
    if (cols_q < COLS_MIN) cols_eff = COLS_MIN;
    if (cols_q > COLS_MAX) cols_eff = COLS_MAX;
    rows_eff = (rows_q < ROWS_MIN) ? ROWS_MIN : rows_q;
    c_eff = ({1'b0, col_pos_q} > cols_eff - COLS_W'(1))
          ? ADDR_W'(cols_eff - COLS_W'(1)) : col_pos_q;
    r_eff = (row_pos_q > rows_eff - ROWS_W'(1)) ? rows_eff - ROWS_W'(1) : row_pos_q;
    c_last = ({1'b0, c_eff} + COLS_W'(1)) >= cols_eff;
    r_last = ({1'b0, r_eff} + 17'd1) >= {1'b0, rows_eff};
    er = r_eff - ROWS_W'(1);
  end

  // handshake
  assign cell_i.ready = rd_ok_q && !skid_v_q;
  assign in_fire      = cell_i.valid && cell_i.ready;
  assign res_v        = in_fire && (r_eff != '0);

  // update decision and four-neighbour mean
  always_comb begin
    upd = 1'b0;
    if (c_eff != '0 && !c_last && er != '0) begin
      if (er >= ROWS_W'(2) && ({1'b0, er} + 17'd3) <= {1'b0, rows_eff}) upd = 1'b1;
      if (er == ROWS_W'(1) && upd_top_q) upd = 1'b1;
      if (({1'b0, er} + 17'd2) == {1'b0, rows_eff} && upd_bot_q) upd = 1'b1;
    end
    sum = {2'b00, up_q} + {2'b00, cell_i.cell_value} + {2'b00, left_q} + {2'b00, right_q};
    res.new_value  = upd ? sum[TEMP_BITS+1:2] : center_q;
    res.out_row    = er;
    res.out_col    = c_eff;
    res.frame_done = (({1'b0, er} + 17'd2) == {1'b0, rows_eff}) && c_last;
  end

  // next position and prefetch address
  always_comb begin
    col_pos_d = col_pos_q;
    row_pos_d = row_pos_q;
    rd_addr   = c_eff;
    if (in_fire) begin
      if (c_last) begin
        col_pos_d = '0;
        row_pos_d = r_last ? '0 : r_eff + ROWS_W'(1);
      end else begin
        col_pos_d = c_eff + ADDR_W'(1);
        row_pos_d = r_eff;
      end
      rd_addr = col_pos_d;
    end
    rd_addr_nxt = rd_addr + ADDR_W'(1);
  end

  // position, left neighbour and prefetch validity
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_pos_q <= '0;
      row_pos_q <= '0;
      left_q    <= '0;
      rd_ok_q   <= 1'b0;
    end else begin
      col_pos_q <= col_pos_d;
      row_pos_q <= row_pos_d;
      rd_ok_q   <= !cfg_we_i;
      if (in_fire) left_q <= center_q;
    end
  end

  // line buffers: one write, reads for the next expected cell
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      row_above_mem[c_eff] <= cell_i.cell_value;
      two_above_mem[c_eff] <= center_q;
    end
    center_q <= row_above_mem[rd_addr];
    right_q  <= row_above_mem[rd_addr_nxt];
    up_q     <= two_above_mem[rd_addr];
  end

  // output register with skid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!main_v_q || result_o.ready) begin
      main_v_q <= skid_v_q || res_v;
      skid_v_q <= 1'b0;
    end else if (res_v) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!main_v_q || result_o.ready) begin
      main_q <= skid_v_q ? skid_q : res;
    end else if (res_v) begin
      skid_q <= res;
    end
  end

  assign result_o.valid      = main_v_q;
  assign result_o.new_value  = main_q.new_value;
  assign result_o.out_row    = main_q.out_row;
  assign result_o.out_col    = main_q.out_col;
  assign result_o.frame_done = main_q.frame_done;

`ifndef ASSERT_OFF
  // skid only fills behind a stalled main register
  a_skid_behind_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> main_v_q)
    else $error("skid register holds a beat while the output register is empty");

  // no beat is taken while prefetched data is stale after a register write
  a_no_accept_after_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !(cell_i.valid && cell_i.ready))
    else $error("input beat accepted right after a register write");

  // end of a row wraps the column position
  a_col_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && c_last |=> col_pos_q == '0)
    else $error("column position did not wrap at end of row");
`endif

endmodule
